/* sv/hbe_pkg.sv */
// Shared constants, command codes and item types for the histogram binning engine.
// No dependencies; every other file imports this package.
`default_nettype none

package hbe_pkg;

	// Store geometry
	localparam int MAX_BINS    = 256;
	localparam int BIN_W       = $clog2(MAX_BINS);
	localparam int COUNT_BITS  = 32;

	// Field widths
	localparam int DATA_W      = 32;
	localparam int NBIN_W      = 9;
	localparam int PROD_W      = DATA_W + NBIN_W;
	localparam int DVS_W       = DATA_W + BIN_W - 1;
	localparam int STEP_W      = $clog2(BIN_W);
	localparam int CMD_W       = 2;
	localparam int IN_TDATA_W  = 48;
	localparam int OUT_TDATA_W = 48;
	localparam int OUT_PAD_W   = OUT_TDATA_W - (BIN_W + COUNT_BITS + 2);

	// Configuration port
	localparam int CFG_IDX_W   = 2;
	localparam logic [CFG_IDX_W-1:0] REG_RANGE_MIN = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RANGE_MAX = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BIN_COUNT = 2'd2;

	// Commands; the same codes travel through the queue
	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
	localparam logic [CMD_W-1:0] CMD_ADD   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;
	localparam logic [CMD_W-1:0] CMD_NONE  = 2'd3;

	// Queue between classifier and store
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic signed [DATA_W-1:0] range_min;
		logic signed [DATA_W-1:0] range_max;
		logic [NBIN_W-1:0]        bin_count;
	} cfg_t;

	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic [BIN_W-1:0] bin;
		logic             below;
	} op_entry_t;

endpackage

`default_nettype wire

/* sv/histogram_binning_engine_top.sv */
// Top level of the histogram binning engine: configuration registers and the
// front end, queue and back end. Depends on hbe_pkg, hbe_front, hbe_queue, hbe_back.
//
// Usage:
//   Input items arrive on the s_ stream: a command (clear, add, read), a signed
//   Q16.16 sample and a bin index. Every item yields exactly one result item on
//   the m_ stream: bin, count, below-range flag and saturation flag.
//   Add maps the sample to one of bin_count equal bins over [range_min,
//   range_max) and bumps that bin's saturating 32-bit counter.
//   Configuration is written through cfg_we/cfg_index/cfg_data while idle.
// Timing:
//   Clear, read, unused codes and adds that clamp (below, above, empty range)
//   are pushed into the queue in the cycle they are accepted. An add that needs
//   the exact bin goes through accept, one 32x9 multiply, 8 restoring divide
//   steps (one quotient bit per cycle) and a push into the queue.
//   The back end takes each item through a registered read of the counter
//   store, then the update and write-back into the output register, and pops
//   the next item only after that write-back.
// Reset:
//   arst_n clears the queue, the state machines and every bin's valid bit, so
//   the whole store reads as zero at once; no sweep is needed.
// Stalls:
//   A result waits in the output register while m_tready is low; the back end
//   and then the two-entry queue fill up before s_tready falls.
`default_nettype none

module histogram_binning_engine_top import hbe_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	// tdata: command[1:0], sample[33:2], read_index[41:34], zero pad above
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	input  wire logic [IN_TDATA_W-1:0]  s_tdata,
	// tdata: bin[7:0], count[39:8], below_range[40], saturated[41], zero pad above
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	output logic [OUT_TDATA_W-1:0]      m_tdata,
	input  wire logic                   cfg_we,
	input  wire logic [CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [DATA_W-1:0]      cfg_data
);

	cfg_t      cfg_q;
	op_entry_t push_data;
	op_entry_t pop_data;
	logic      q_push;
	logic      q_full;
	logic      q_pop;
	logic      q_empty;

	// Configuration registers; writes past the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.range_min <= DATA_W'(0);
			cfg_q.range_max <= DATA_W'(65536);
			cfg_q.bin_count <= NBIN_W'(16);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_RANGE_MIN: cfg_q.range_min <= cfg_data;
				REG_RANGE_MAX: cfg_q.range_max <= cfg_data;
				REG_BIN_COUNT: cfg_q.bin_count <= cfg_data[NBIN_W-1:0];
				default: ;
			endcase
		end
	end

	// Classify items and resolve the bin of each sample
	hbe_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_data   (push_data)
	);

	// Decouple the divider from the store so each can stall on its own
	hbe_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (pop_data),
		.empty     (q_empty)
	);

	// Update or read the counter store and hold the result
	hbe_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.q_pop    (q_pop),
		.q_data   (pop_data),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

`default_nettype wire

/* sv/hbe_queue.sv */
// Two-entry register queue carrying classified operations from front to back.
// Depends on hbe_pkg.
`default_nettype none

module hbe_queue import hbe_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      push,
	input  wire op_entry_t push_data,
	output logic           full,
	input  wire logic      pop,
	output op_entry_t      pop_data,
	output logic           empty
);

	op_entry_t          entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wptr_q;
	logic [QPTR_W-1:0]  rptr_q;
	logic [QCNT_W-1:0]  cnt_q;
	logic               do_push;
	logic               do_pop;

	assign full     = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign empty    = (cnt_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = entry_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_push) wptr_q <= wptr_q + 1'b1;
			if (do_pop)  rptr_q <= rptr_q + 1'b1;
			if (do_push && !do_pop)      cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) entry_q[wptr_q] <= push_data;
	end

endmodule

`default_nettype wire

/* sv/hbe_front.sv */
// Front end: accepts items, classifies them and finds the bin of each sample
// with a multiply and a one-bit-per-cycle restoring divider. Depends on hbe_pkg.
`default_nettype none

module hbe_front import hbe_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire cfg_t                  cfg,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [IN_TDATA_W-1:0] s_tdata,
	input  wire logic                  q_full,
	output logic                       q_push,
	output op_entry_t                  q_data
);

	localparam logic [1:0] F_IDLE = 2'd0;
	localparam logic [1:0] F_MUL  = 2'd1;
	localparam logic [1:0] F_DIV  = 2'd2;
	localparam logic [1:0] F_PUSH = 2'd3;

	logic [1:0]               state_q;
	logic [CMD_W-1:0]         cmd;
	logic signed [DATA_W-1:0] smp;
	logic [BIN_W-1:0]         ridx;
	logic [NBIN_W-1:0]        n_c;
	logic [BIN_W-1:0]         last_bin;
	logic                     below;
	logic                     empty_rng;
	logic                     above;
	logic                     accept;
	logic                     need_div;
	logic [DATA_W:0]          diff_c;
	logic [DATA_W:0]          span_c;
	logic [PROD_W-1:0]        trial;
	logic                     ge;

	logic [DATA_W-1:0]        diff_q;
	logic [DATA_W-1:0]        span_q;
	logic [NBIN_W-1:0]        n_q;
	logic [PROD_W-1:0]        prod_q;
	logic [DVS_W-1:0]         dvs_q;
	logic [BIN_W-1:0]         quo_q;
	logic [STEP_W-1:0]        step_q;

	assign cmd  = s_tdata[CMD_W-1:0];
	assign smp  = $signed(s_tdata[CMD_W+DATA_W-1:CMD_W]);
	assign ridx = s_tdata[CMD_W+DATA_W+BIN_W-1:CMD_W+DATA_W];

	// Bins in use: zero counts as one, anything past the store is capped
	always_comb begin
		if (cfg.bin_count == '0)                         n_c = NBIN_W'(1);
		else if (cfg.bin_count > NBIN_W'(MAX_BINS))      n_c = NBIN_W'(MAX_BINS);
		else                                             n_c = cfg.bin_count;
	end
	assign last_bin = BIN_W'(n_c - 1'b1);

	assign below     = $signed(smp) < $signed(cfg.range_min);
	assign empty_rng = $signed(cfg.range_max) <= $signed(cfg.range_min);
	assign above     = $signed(smp) >= $signed(cfg.range_max);
	assign diff_c    = {smp[DATA_W-1], smp} - {cfg.range_min[DATA_W-1], cfg.range_min};
	assign span_c    = {cfg.range_max[DATA_W-1], cfg.range_max}
	                 - {cfg.range_min[DATA_W-1], cfg.range_min};

	assign s_tready = (state_q == F_IDLE) && !q_full;
	assign accept   = s_tvalid && s_tready;
	assign need_div = (cmd == CMD_ADD) && !below && !empty_rng && !above;

	assign trial = PROD_W'(dvs_q);
	assign ge    = prod_q >= trial;

	always_comb begin
		q_push = 1'b0;
		q_data = '0;
		if (state_q == F_IDLE) begin
			if (accept && !need_div) begin
				q_push       = 1'b1;
				q_data.cmd   = cmd;
				q_data.below = (cmd == CMD_ADD) && below;
				if (cmd == CMD_READ)
					q_data.bin = ridx;
				else if (cmd == CMD_ADD && !below && !empty_rng && above)
					q_data.bin = last_bin;
			end
		end else if (state_q == F_PUSH) begin
			q_push     = !q_full;
			q_data.cmd = CMD_ADD;
			q_data.bin = quo_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			unique case (state_q)
				F_IDLE: if (accept && need_div) state_q <= F_MUL;
				F_MUL:  state_q <= F_DIV;
				F_DIV:  if (step_q == '0) state_q <= F_PUSH;
				F_PUSH: if (!q_full) state_q <= F_IDLE;
				default: state_q <= F_IDLE;
			endcase
		end
	end

	// Datapath: hold operands, multiply once, then peel one quotient bit a cycle
	always_ff @(posedge clk) begin
		unique case (state_q)
			F_IDLE: begin
				diff_q <= diff_c[DATA_W-1:0];
				span_q <= span_c[DATA_W-1:0];
				n_q    <= n_c;
			end
			F_MUL: begin
				prod_q <= {{NBIN_W{1'b0}}, diff_q} * {{DATA_W{1'b0}}, n_q};
				dvs_q  <= {span_q, {(BIN_W-1){1'b0}}};
				step_q <= STEP_W'(BIN_W - 1);
				quo_q  <= '0;
			end
			F_DIV: begin
				if (ge) prod_q <= prod_q - trial;
				quo_q  <= {quo_q[BIN_W-2:0], ge};
				dvs_q  <= dvs_q >> 1;
				step_q <= step_q - 1'b1;
			end
			default: ;
		endcase
	end

endmodule

`default_nettype wire

/* sv/hbe_back.sv */
// Back end: counter store with read-modify-write, clear and read, plus the
// output register. Depends on hbe_pkg.
`default_nettype none

module hbe_back import hbe_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   q_empty,
	output logic                        q_pop,
	input  wire op_entry_t              q_data,
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	output logic [OUT_TDATA_W-1:0]      m_tdata
);

	localparam logic B_IDLE = 1'b0;
	localparam logic B_RMW  = 1'b1;

	logic                   state_q;
	op_entry_t              op_s1;
	logic [COUNT_BITS-1:0]  mem [MAX_BINS];
	logic [COUNT_BITS-1:0]  rdata_q;
	logic [MAX_BINS-1:0]    vld_q;
	logic                   m_tvalid_q;
	logic [OUT_TDATA_W-1:0] m_tdata_q;

	logic                   fire;
	logic                   wr_en;
	logic [COUNT_BITS-1:0]  cur;
	logic [COUNT_BITS-1:0]  nxt;
	logic                   full_cnt;
	logic [BIN_W-1:0]       res_bin;
	logic [COUNT_BITS-1:0]  res_cnt;
	logic                   res_below;
	logic                   res_sat;

	assign q_pop    = (state_q == B_IDLE) && !q_empty;
	assign fire     = (state_q == B_RMW) && (!m_tvalid_q || m_tready);
	assign wr_en    = fire && (op_s1.cmd == CMD_ADD);

	// A bin never written since the last clear reads as zero
	assign cur      = vld_q[op_s1.bin] ? rdata_q : '0;
	assign full_cnt = &cur;
	assign nxt      = full_cnt ? cur : cur + 1'b1;

	always_comb begin
		res_bin   = '0;
		res_cnt   = '0;
		res_below = 1'b0;
		res_sat   = 1'b0;
		unique case (op_s1.cmd)
			CMD_ADD: begin
				res_bin   = op_s1.bin;
				res_cnt   = nxt;
				res_below = op_s1.below;
				res_sat   = full_cnt;
			end
			CMD_READ: begin
				res_bin = op_s1.bin;
				res_cnt = cur;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[op_s1.bin] <= nxt;
		if (q_pop) rdata_q <= mem[q_data.bin];
	end

	always_ff @(posedge clk) begin
		if (q_pop) op_s1 <= q_data;
		if (fire)  m_tdata_q <= {{OUT_PAD_W{1'b0}}, res_sat, res_below, res_cnt, res_bin};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= B_IDLE;
			vld_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			unique case (state_q)
				B_IDLE: if (q_pop) state_q <= B_RMW;
				B_RMW:  if (fire)  state_q <= B_IDLE;
				default: state_q <= B_IDLE;
			endcase
			if (fire) begin
				if (op_s1.cmd == CMD_CLEAR)    vld_q <= '0;
				else if (op_s1.cmd == CMD_ADD) vld_q[op_s1.bin] <= 1'b1;
			end
			if (fire)          m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

`default_nettype wire
